### sv/gswp_pkg.sv
// ---------------------------------------------------------------------------
// gswp_pkg
// shared constants, types and table functions of the grid sine-warp generator
// ---------------------------------------------------------------------------
`default_nettype none
package gswp_pkg;

    localparam int MAX_GRID_DEF   = 4096;
    localparam int SINE_DEPTH_DEF = 256;
    localparam int CNT_W          = 13;
    localparam int COORD_W        = 20;
    localparam int WARP_W         = 21;
    localparam int SINE_W         = 16;
    localparam int ADDR_W         = 5;
    localparam logic [63:0] TURN_K = 64'd174992710547;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [ADDR_W-1:0] REG_COUNT_X = 5'd0;
    localparam logic [ADDR_W-1:0] REG_COUNT_Y = 5'd4;
    localparam logic [ADDR_W-1:0] REG_COUNT_Z = 5'd8;
    localparam logic [ADDR_W-1:0] REG_STEP_X  = 5'd12;
    localparam logic [ADDR_W-1:0] REG_STEP_Y  = 5'd16;
    localparam logic [ADDR_W-1:0] REG_STEP_Z  = 5'd20;

    typedef struct packed {
        logic                      last;
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
        logic [COORD_W-1:0]        z;
    } t_point;

    typedef struct packed {
        logic restart;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0] ref_x;
        logic [COORD_W-1:0] ref_y;
        logic [COORD_W-1:0] ref_z;
        logic [WARP_W-1:0]  warped_x;
        logic [WARP_W-1:0]  warped_y;
        logic [WARP_W-1:0]  warped_z;
        logic               last_point;
    } t_res;

    // quarter-wave sine entry, Q15, from an integer series in Q30
    function automatic logic [SINE_W-1:0] sine_entry(input int k, input int depth);
        logic [127:0] x, x2, term, pos, neg, sum, val;
        int n;
        x = ((128'(2 * k + 1)) * 128'(PI_Q30)) >> (2 + $clog2(depth));
        x2 = (x * x) >> 30;
        term = x;
        pos = '0;
        neg = '0;
        for (n = 1; n <= 15; n += 2) begin
            // odd powers alternate in sign
            if (!n[1]) pos = pos + term;
            else neg = neg + term;
            term = ((term * x2) >> 30) / 128'((n + 1) * (n + 2));
        end
        sum = (pos > neg) ? pos - neg : '0;
        val = (sum * 128'd32767 + (128'd1 << 29)) >> 30;
        if (val > 128'd32767) val = 128'd32767;
        return val[SINE_W-1:0];
    endfunction

endpackage
`default_nettype wire

### sv/gswp_if.sv
// ---------------------------------------------------------------------------
// gswp_if
// valid/ready channel carrying one payload
// ---------------------------------------------------------------------------
`default_nettype none
interface gswp_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/gswp_walk.sv
// ---------------------------------------------------------------------------
// gswp_walk
// front: accepts requests, steps the grid indices, forms reference points
// ---------------------------------------------------------------------------
`default_nettype none
module gswp_walk #(
    parameter int MAX_GRID = gswp_pkg::MAX_GRID_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_restart,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [gswp_pkg::CNT_W-1:0]   i_count_x,
    input  wire logic [gswp_pkg::CNT_W-1:0]   i_count_y,
    input  wire logic [gswp_pkg::CNT_W-1:0]   i_count_z,
    input  wire logic [gswp_pkg::COORD_W-1:0] i_step_x,
    input  wire logic [gswp_pkg::COORD_W-1:0] i_step_y,
    input  wire logic [gswp_pkg::COORD_W-1:0] i_step_z,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output gswp_pkg::t_point                  o_point
);
    import gswp_pkg::*;
    localparam int IDX_W = $clog2(MAX_GRID + 1);
    localparam int PW    = IDX_W + COORD_W;

    logic [IDX_W-1:0] r_ix, r_iy, r_iz, n_ix, n_iy, n_iz;
    logic [IDX_W-1:0] cx, cy, cz, ux, uy, uz;
    logic             end_x, end_y, end_z, take;
    logic [PW-1:0]    px, py, pz;
    t_point           r_point;
    logic             r_valid;

    function automatic logic [IDX_W-1:0] eff(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        if (w == 0) return IDX_W'(1);
        if (w > 32'(MAX_GRID)) return IDX_W'(MAX_GRID);
        return IDX_W'(w);
    endfunction

    function automatic logic [COORD_W-1:0] sat(input logic [PW-1:0] v);
        return (v > PW'({COORD_W{1'b1}})) ? {COORD_W{1'b1}} : v[COORD_W-1:0];
    endfunction

    assign cx = eff(i_count_x);
    assign cy = eff(i_count_y);
    assign cz = eff(i_count_z);
    assign ux = i_restart ? '0 : r_ix;
    assign uy = i_restart ? '0 : r_iy;
    assign uz = i_restart ? '0 : r_iz;
    assign end_x = (IDX_W+1)'(ux) + 1'b1 >= (IDX_W+1)'(cx);
    assign end_y = (IDX_W+1)'(uy) + 1'b1 >= (IDX_W+1)'(cy);
    assign end_z = (IDX_W+1)'(uz) + 1'b1 >= (IDX_W+1)'(cz);
    assign px = PW'(ux) * PW'(i_step_x);
    assign py = PW'(uy) * PW'(i_step_y);
    assign pz = PW'(uz) * PW'(i_step_z);

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_ix = ux;
        n_iy = uy;
        n_iz = uz;
        if (!end_y) begin
            n_iy = uy + 1'b1;
        end else begin
            n_iy = '0;
            if (!end_x) begin
                n_ix = ux + 1'b1;
            end else begin
                n_ix = '0;
                n_iz = end_z ? '0 : uz + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ix <= '0;
            r_iy <= '0;
            r_iz <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_ix <= n_ix;
                r_iy <= n_iy;
                r_iz <= n_iz;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_point.x <= sat(px);
            r_point.y <= sat(py);
            r_point.z <= sat(pz);
            r_point.last <= end_x && end_y && end_z;
        end
    end

    assign o_valid = r_valid;
    assign o_point = r_point;
endmodule
`default_nettype wire

### sv/gswp_fifo.sv
// ---------------------------------------------------------------------------
// gswp_fifo
// two-entry queue between the walk and the warp stages
// ---------------------------------------------------------------------------
`default_nettype none
module gswp_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire gswp_pkg::t_point i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output gswp_pkg::t_point      o_data
);
    import gswp_pkg::*;
    t_point     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

### sv/gswp_warp.sv
// ---------------------------------------------------------------------------
// gswp_warp
// back: phase products, table lookups and warp sums over three stages
// ---------------------------------------------------------------------------
`default_nettype none
module gswp_warp #(
    parameter int SINE_DEPTH = gswp_pkg::SINE_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire gswp_pkg::t_point             i_point,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [gswp_pkg::COORD_W-1:0]      o_ref_x,
    output logic [gswp_pkg::COORD_W-1:0]      o_ref_y,
    output logic [gswp_pkg::COORD_W-1:0]      o_ref_z,
    output logic signed [gswp_pkg::WARP_W-1:0] o_warped_x,
    output logic signed [gswp_pkg::WARP_W-1:0] o_warped_y,
    output logic signed [gswp_pkg::WARP_W-1:0] o_warped_z,
    output logic                              o_last_point
);
    import gswp_pkg::*;
    localparam int PH_W = $clog2(4 * SINE_DEPTH);
    localparam int R_W  = $clog2(SINE_DEPTH);
    localparam int NT   = 6;

    // product v*K: 20 x 38 bits, split into two 20 x 19 partial products
    localparam int KL_W = 19;
    localparam logic [KL_W-1:0] K_LO = TURN_K[KL_W-1:0];
    localparam logic [KL_W-1:0] K_HI = TURN_K[2*KL_W-1:KL_W];

    logic [SINE_W-1:0] rom [SINE_DEPTH];
    for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_rom
        localparam logic [SINE_W-1:0] ENTRY = sine_entry(g, SINE_DEPTH);
        assign rom[g] = ENTRY;
    end

    // stage 1: partial products, stage 2: phases, stage 3: warps
    logic                 r_v1, r_v2, r_v3;
    t_point               r_p1, r_p2;
    logic [KL_W+COORD_W-1:0] r_lo [3];
    logic [KL_W+COORD_W-1:0] r_hi [3];
    logic [PH_W-1:0]      r_ph [NT];
    logic                 adv1, adv2, adv3;

    assign adv3 = !r_v3 || i_ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;

    logic [COORD_W-1:0] vin [3];
    assign vin[0] = i_point.x;
    assign vin[1] = i_point.y;
    assign vin[2] = i_point.z;

    // term sources: 0 sin(y/32) 1 cos(z/16) 2 cos(z/8) 3 sin(x/32) 4 sin(x/16) 5 cos(y/16)
    localparam int SRC [NT] = '{1, 2, 2, 0, 0, 1};
    localparam int SH  [NT] = '{13, 12, 11, 13, 12, 12};
    localparam bit COS [NT] = '{0, 1, 1, 0, 0, 1};

    logic [PH_W-1:0] n_ph [NT];
    always_comb begin
        logic [79:0] full;
        logic [79:0] t;
        for (int i = 0; i < NT; i++) begin
            full = (80'(r_hi[SRC[i]]) << KL_W) + 80'(r_lo[SRC[i]]);
            t = full >> SH[i];
            n_ph[i] = t[39 -: PH_W] + (COS[i] ? PH_W'(SINE_DEPTH) : '0);
        end
    end

    function automatic logic signed [SINE_W:0] sine_at(input logic [PH_W-1:0] p,
                                                       input logic [SINE_W-1:0] a,
                                                       input logic [SINE_W-1:0] b);
        logic [SINE_W-1:0] m;
        m = p[R_W] ? b : a;
        return p[R_W+1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [23:0] term(input int amp,
                                                input logic signed [SINE_W:0] s);
        logic signed [31:0] num;
        num = 32'(amp) * (32'(s) + 32'sd32768) + 32'sd64;
        return 24'((num >>> 7) - 32'(amp * 256));
    endfunction

    function automatic logic [WARP_W-1:0] clip(input logic signed [23:0] v);
        if (v < -24'sd1048576) return WARP_W'(-21'sd1048576);
        if (v > 24'sd1048575) return WARP_W'(21'sd1048575);
        return v[WARP_W-1:0];
    endfunction

    logic signed [SINE_W:0] s [NT];
    always_comb begin
        logic [R_W-1:0] r;
        for (int i = 0; i < NT; i++) begin
            r = r_ph[i][R_W-1:0];
            s[i] = sine_at(r_ph[i], rom[r], rom[R_W'(SINE_DEPTH - 1) - r]);
        end
    end

    logic signed [23:0] wx, wy, wz;
    assign wx = 24'(r_p2.x) - term(2, s[0]) + term(2, s[1]);
    assign wy = 24'(r_p2.y) + term(4, s[2]) - term(8, s[3]);
    assign wz = 24'(r_p2.z) - term(2, s[4]) + term(4, s[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_p1 <= i_point;
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= (KL_W+COORD_W)'(vin[a]) * (KL_W+COORD_W)'(K_LO);
                r_hi[a] <= (KL_W+COORD_W)'(vin[a]) * (KL_W+COORD_W)'(K_HI);
            end
        end
        if (adv2 && r_v1) begin
            r_p2 <= r_p1;
            for (int i = 0; i < NT; i++) r_ph[i] <= n_ph[i];
        end
        if (adv3 && r_v2) begin
            o_ref_x <= r_p2.x;
            o_ref_y <= r_p2.y;
            o_ref_z <= r_p2.z;
            o_last_point <= r_p2.last;
            o_warped_x <= clip(wx);
            o_warped_y <= clip(wy);
            o_warped_z <= clip(wz);
        end
    end

    assign o_valid = r_v3;
endmodule
`default_nettype wire

### sv/grid_sine_warp_point_generator_top.sv
// ---------------------------------------------------------------------------
// grid_sine_warp_point_generator_top
// grid walk with reference and sine-warped control points
// ---------------------------------------------------------------------------
// path: a request beat passes the walk register, the queue and the three warp stages
// before its result is valid
// throughput: one beat per cycle while the result side is ready; the index counters update on each accepted beat
// reset: synchronous active low; indices zero, counts 1, steps 0, pipes empty
`default_nettype none
module grid_sine_warp_point_generator_top #(
    parameter int MAX_GRID   = gswp_pkg::MAX_GRID_DEF,
    parameter int SINE_DEPTH = gswp_pkg::SINE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    gswp_if.sink                             i_req,
    gswp_if.source                           o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gswp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import gswp_pkg::*;

    logic [CNT_W-1:0]   r_count_x, r_count_y, r_count_z;
    logic [COORD_W-1:0] r_step_x, r_step_y, r_step_z;
    logic               wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_x <= CNT_W'(1);
            r_count_y <= CNT_W'(1);
            r_count_z <= CNT_W'(1);
            r_step_x <= '0;
            r_step_y <= '0;
            r_step_z <= '0;
        end else if (wr) begin
            unique case (paddr)
                REG_COUNT_X: r_count_x <= pwdata[CNT_W-1:0];
                REG_COUNT_Y: r_count_y <= pwdata[CNT_W-1:0];
                REG_COUNT_Z: r_count_z <= pwdata[CNT_W-1:0];
                REG_STEP_X:  r_step_x <= pwdata[COORD_W-1:0];
                REG_STEP_Y:  r_step_y <= pwdata[COORD_W-1:0];
                REG_STEP_Z:  r_step_z <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            REG_COUNT_X: prdata = 32'(r_count_x);
            REG_COUNT_Y: prdata = 32'(r_count_y);
            REG_COUNT_Z: prdata = 32'(r_count_z);
            REG_STEP_X:  prdata = 32'(r_step_x);
            REG_STEP_Y:  prdata = 32'(r_step_y);
            REG_STEP_Z:  prdata = 32'(r_step_z);
            default:     prdata = '0;
        endcase
    end

    logic   w_valid, w_ready, q_valid, q_ready;
    t_point w_point, q_point;

    gswp_walk #(.MAX_GRID(MAX_GRID)) u_walk (
        .i_clk, .i_rst_n,
        .i_restart(i_req.data.restart), .i_valid(i_req.valid), .o_ready(i_req.ready),
        .i_count_x(r_count_x), .i_count_y(r_count_y), .i_count_z(r_count_z),
        .i_step_x(r_step_x), .i_step_y(r_step_y), .i_step_z(r_step_z),
        .o_valid(w_valid), .i_ready(w_ready), .o_point(w_point)
    );

    gswp_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(w_valid), .o_ready(w_ready), .i_data(w_point),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_point)
    );

    gswp_warp #(.SINE_DEPTH(SINE_DEPTH)) u_warp (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_point(q_point),
        .o_valid(o_res.valid), .i_ready(o_res.ready),
        .o_ref_x(o_res.data.ref_x), .o_ref_y(o_res.data.ref_y), .o_ref_z(o_res.data.ref_z),
        .o_warped_x(o_res.data.warped_x), .o_warped_y(o_res.data.warped_y),
        .o_warped_z(o_res.data.warped_z), .o_last_point(o_res.data.last_point)
    );

    a_ref_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid) else $error("result dropped");
    a_q_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && !q_ready |=> q_valid && $stable(q_point)) else $error("queue head moved");
    a_walk_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid && !w_ready |=> w_valid && $stable(w_point)) else $error("walk point lost");
endmodule
`default_nettype wire
